>>> rtl/lwa_pkg.sv
`default_nettype none

package lwa_pkg;

    localparam int GRID_POINTS_DEF = 64;

    localparam int DATA_W  = 16;
    localparam int CFG_W   = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Shared multiplier: 17-bit coefficient times 19-bit difference.
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 14;
    localparam int SH_W    = ACC_W - FRAC_W;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [SH_W-1:0]  SAT_HI     = SH_W'(32767);
    localparam logic signed [SH_W-1:0]  SAT_LO     = -SH_W'(32768);

    localparam logic [CFG_W-1:0] STEP_COUNT_RST      = CFG_W'(30);
    localparam logic [CFG_W-1:0] HALF_COURANT_RST    = CFG_W'(8192);
    localparam logic [CFG_W-1:0] HALF_COURANT_SQ_RST = CFG_W'(8192);

    localparam logic [1:0] REG_STEP_COUNT      = 2'd0;
    localparam logic [1:0] REG_HALF_COURANT    = 2'd1;
    localparam logic [1:0] REG_HALF_COURANT_SQ = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     last;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } t_out;

    typedef struct packed {
        logic [CFG_W-1:0] step_count;
        logic [CFG_W-1:0] half_courant;
        logic [CFG_W-1:0] half_courant_sq;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_STEP,
        ST_LEFT,
        ST_CENTER,
        ST_MUL1,
        ST_MUL2,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_HOLD
    } t_state;

endpackage

`default_nettype wire

>>> rtl/lwa_regs.sv
`default_nettype none

module lwa_regs
    import lwa_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [PADDR_W-1:0] paddr,
    input  wire  [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_STEP_COUNT:      n_cfg.step_count      = pwdata[CFG_W-1:0];
                REG_HALF_COURANT:    n_cfg.half_courant    = pwdata[CFG_W-1:0];
                REG_HALF_COURANT_SQ: n_cfg.half_courant_sq = pwdata[CFG_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STEP_COUNT:      prdata = PDATA_W'(r_cfg.step_count);
            REG_HALF_COURANT:    prdata = PDATA_W'(r_cfg.half_courant);
            REG_HALF_COURANT_SQ: prdata = PDATA_W'(r_cfg.half_courant_sq);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_count      <= STEP_COUNT_RST;
            r_cfg.half_courant    <= HALF_COURANT_RST;
            r_cfg.half_courant_sq <= HALF_COURANT_SQ_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/lax_wendroff_advection_solver_top.sv
// Lax-Wendroff solver for 1D linear advection on a grid of signed Q8.8 samples.
// The input channel takes one grid sample per word, one per cycle, in grid order.
// A word flagged last ends the load; samples beyond GRID_POINTS are dropped.
// The block then applies step_count updates to every point but the first and
// streams the final grid on the output channel, is_last marking the final point.
// A single shared multiplier serves both products of each point, so each point
// passes through the states ST_MUL1, ST_MUL2 and ST_WRITE in turn.
// No step runs when step_count is zero or only a single point is loaded.
// Each output word passes through ST_OUT_RD, ST_OUT_LD and ST_OUT_HOLD; a stall
// holds the word and the block waits. Input is not accepted from the last word
// until the final output word is taken. The user must write the registers over
// the APB port only while the block is idle; the block itself does not enforce it.
// Reset restores the register defaults and starts a new, empty load.
`default_nettype none

module lax_wendroff_advection_solver_top
    import lwa_pkg::*;
#(
    parameter int GRID_POINTS = GRID_POINTS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  t_in                i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output t_out               o_out_data,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [PADDR_W-1:0] paddr,
    input  wire  [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int IDX_W = $clog2(GRID_POINTS);
    localparam int CNT_W = $clog2(GRID_POINTS + 1);

    t_cfg cfg;

    lwa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic signed [DATA_W-1:0] mem [GRID_POINTS];

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_load_cnt, n_load_cnt;
    logic [CNT_W-1:0]         r_n, n_n;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [CFG_W-1:0]         r_steps, n_steps;
    logic signed [DATA_W-1:0] r_left, n_left;
    logic signed [DATA_W-1:0] r_u, n_u;
    logic signed [DATA_W-1:0] r_right, n_right;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [DATA_W-1:0] r_rd;
    t_out                     r_out, n_out;
    logic                     r_out_valid, n_out_valid;

    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]         rd_addr;

    logic [CNT_W-1:0]          idx_nxt;
    logic [CNT_W-1:0]          idx_nxt2;
    logic signed [DATA_W-1:0]  right_sel;
    logic signed [MUL_B_W-1:0] diff1;
    logic signed [MUL_B_W-1:0] diff2;
    logic                      mul_sel;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]   sum;
    logic signed [SH_W-1:0]    shifted;
    logic signed [DATA_W-1:0]  sat;

    assign idx_nxt   = r_idx + CNT_W'(1);
    assign idx_nxt2  = idx_nxt + CNT_W'(1);
    assign right_sel = (idx_nxt < r_n) ? r_rd : '0;
    assign diff1     = MUL_B_W'(right_sel) - MUL_B_W'(r_left);
    assign diff2     = MUL_B_W'(r_right) - (MUL_B_W'(r_u) <<< 1) + MUL_B_W'(r_left);

    // The one multiplier: the advection term first, the diffusion term next.
    assign mul_a = mul_sel ? MUL_A_W'({1'b0, cfg.half_courant_sq})
                           : MUL_A_W'({1'b0, cfg.half_courant});
    assign mul_b = mul_sel ? diff2 : diff1;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    assign sum     = r_acc + ACC_W'(r_prod) + ROUND_HALF;
    assign shifted = sum[ACC_W-1:FRAC_W];
    assign sat     = (shifted > SAT_HI) ? DATA_W'(SAT_HI) :
                     (shifted < SAT_LO) ? DATA_W'(SAT_LO) : shifted[DATA_W-1:0];

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_load_cnt  = r_load_cnt;
        n_n         = r_n;
        n_idx       = r_idx;
        n_steps     = r_steps;
        n_left      = r_left;
        n_u         = r_u;
        n_right     = r_right;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        we          = 1'b0;
        waddr       = r_load_cnt[IDX_W-1:0];
        wdata       = i_in_data.sample;
        rd_addr     = '0;
        mul_sel     = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (r_load_cnt < CNT_W'(GRID_POINTS)) begin
                        we         = 1'b1;
                        n_load_cnt = r_load_cnt + CNT_W'(1);
                    end
                    if (i_in_data.last) begin
                        n_n        = n_load_cnt;
                        n_load_cnt = '0;
                        n_steps    = '0;
                        n_idx      = '0;
                        if (cfg.step_count == '0 || n_n == CNT_W'(1)) begin
                            n_state = ST_OUT_RD;
                        end else begin
                            n_state = ST_STEP;
                        end
                    end
                end
            end
            ST_STEP: begin
                rd_addr = '0;
                n_idx   = CNT_W'(1);
                n_state = ST_LEFT;
            end
            ST_LEFT: begin
                n_left  = r_rd;
                rd_addr = IDX_W'(1);
                n_state = ST_CENTER;
            end
            ST_CENTER: begin
                n_u     = r_rd;
                rd_addr = IDX_W'(2);
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                mul_sel = 1'b0;
                n_right = right_sel;
                n_prod  = mul_p;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                mul_sel = 1'b1;
                n_acc   = (ACC_W'(r_u) <<< FRAC_W) - ACC_W'(r_prod);
                n_prod  = mul_p;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                we      = 1'b1;
                waddr   = r_idx[IDX_W-1:0];
                wdata   = sat;
                n_left  = r_u;
                n_u     = r_right;
                n_idx   = idx_nxt;
                rd_addr = idx_nxt2[IDX_W-1:0];
                if (idx_nxt < r_n) begin
                    n_state = ST_MUL1;
                end else begin
                    n_steps = r_steps + CFG_W'(1);
                    if (n_steps == cfg.step_count) begin
                        n_idx   = '0;
                        n_state = ST_OUT_RD;
                    end else begin
                        n_state = ST_STEP;
                    end
                end
            end
            ST_OUT_RD: begin
                rd_addr = r_idx[IDX_W-1:0];
                n_state = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                n_out.value   = r_rd;
                n_out.is_last = (idx_nxt == r_n);
                n_out_valid   = 1'b1;
                n_state       = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_idx       = idx_nxt;
                    if (r_out.is_last) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt  <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_n         <= '0;
            r_steps     <= '0;
        end else begin
            r_load_cnt  <= n_load_cnt;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_steps     <= n_steps;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left  <= n_left;
        r_u     <= n_u;
        r_right <= n_right;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[rd_addr];
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && o_in_ready))
        else $error("Input accepted while an output word is pending.");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt <= CNT_W'(GRID_POINTS))
        else $error("Load count exceeds the grid size.");

    a_point_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL1 || r_state == ST_MUL2 || r_state == ST_WRITE)
        |-> (r_idx < r_n && r_idx != '0))
        else $error("Update addresses a point outside the loaded grid.");

    a_last_word_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.is_last) |=> o_in_ready)
        else $error("Load did not resume after the final output word.");

endmodule

`default_nettype wire
